// ===== sv/btve_pkg.sv =====
// Shared types and constants of the varint trace encoder.
package btve_pkg;

  // input op codes
  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_EVENT = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [7:0] CFG_CODE_END    = 8'd0;
  localparam logic [7:0] CFG_CODE_DEFINE = 8'd1;
  localparam logic [7:0] CFG_CODE_CYCLE  = 8'd2;
  localparam logic [7:0] CFG_CODE_ARRAYW = 8'd3;

  // configuration reset values
  localparam logic [7:0] RST_CODE_END    = 8'd0;
  localparam logic [7:0] RST_CODE_DEFINE = 8'd1;
  localparam logic [7:0] RST_CODE_CYCLE  = 8'd2;
  localparam logic [7:0] RST_CODE_ARRAYW = 8'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

  // pieces of a record, in stream order
  typedef enum logic [4:0] {
    SEG_NONE,
    SEG_DEF_ZERO,
    SEG_DEF_CODE,
    SEG_DEF_ID,
    SEG_DEF_VA,
    SEG_DEF_PA,
    SEG_DEF_SIZE,
    SEG_DEF_HASH,
    SEG_CYC_ZERO,
    SEG_CYC_CODE,
    SEG_CYC_DELTA,
    SEG_ID1,
    SEG_EV_ZERO,
    SEG_EV_CODE,
    SEG_ARG1,
    SEG_ARG2,
    SEG_END_ZERO,
    SEG_END_CODE
  } seg_t;

  // control of the shared shift unit
  typedef struct packed {
    logic load;
    logic step;
    logic raw;
  } vu_ctl_t;

  // status of the shared shift unit
  typedef struct packed {
    logic [7:0] data;
    logic       more;
  } vu_stat_t;

endpackage

// ===== sv/btve_seen_map.sv =====
// Bitmap of defined blocks, with a clearing sweep after reset.
module btve_seen_map #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  output logic          ready
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic          mem [DEPTH];
  logic          rd_data_r;
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // clearing sweep, one entry a cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // storage: clear writes 0, marking writes 1; registered read
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= 1'b1;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clr_busy_r;

endmodule

// ===== sv/btve_varint_unit.sv =====
// Shared shift unit: peels one LEB128 byte a step off a 64-bit value.
module btve_varint_unit (
  input  logic               clk,
  input  btve_pkg::vu_ctl_t  ctl,
  input  logic [63:0]        ld_value,
  output btve_pkg::vu_stat_t stat
);

  logic [63:0] value_r;
  logic        raw_r;
  logic        more;

  // load a fresh value, or drop the seven bits just sent
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value_r <= ld_value;
      raw_r   <= ctl.raw;
    end else if (ctl.step) begin
      value_r <= value_r >> 7;
    end
  end

  // raw bytes go out as they are; varint groups carry a continuation bit
  assign more       = !raw_r && (value_r[63:7] != '0);
  assign stat.more  = more;
  assign stat.data  = raw_r ? value_r[7:0] : {more, value_r[6:0]};

endmodule

// ===== sv/block_trace_varint_encoder_core.sv =====
// Top level of the varint trace encoder: sequencer, state and output register.
//
// Input words arrive on in_valid/in_ready and carry one trace event each.
// Every event becomes a run of bytes on out_valid/out_ready, one byte per word,
// with out_last high on the final byte of the event. Op code 3 is dropped.
// Codes of the record headers are set through cfg_valid/cfg_ready with
// cfg_index and cfg_wdata; write them only while the block is idle.
//
// An event occupies the block for the bitmap lookup and state update, then
// for its bytes, one a cycle while the receiver takes them, from the shared
// shift unit, which emits a 64-bit value seven bits at a time. A typical
// execute event is one to three bytes long. After acceptance the event
// passes the lookup state; its first byte moves into the output register
// from the emit state. in_ready rises again the cycle after the last byte
// enters the output register, so the next event is taken while it waits.
//
// After reset the block-seen bitmap is swept to zero, one entry a cycle, over
// all MAX_BLOCKS entries; in_ready stays low meanwhile, cfg writes are taken.
// A stalled receiver holds the output word and the sequencer waits with it.
module block_trace_varint_encoder_core #(
  parameter int MAX_BLOCKS   = 65536,
  parameter int BUCKET_SHIFT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // event input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_block_id,
  input  logic [31:0] in_virt_addr,
  input  logic [31:0] in_phys_addr,
  input  logic [31:0] in_block_bytes,
  input  logic [31:0] in_block_hash,
  input  logic [63:0] in_cycle_count,
  input  logic [7:0]  in_event_code,
  input  logic [31:0] in_arg_first,
  input  logic [31:0] in_arg_second,
  // byte output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int MAP_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BKT_W  = 64 - BUCKET_SHIFT;

  // configuration
  logic [7:0] code_end_r, code_define_r, code_cycle_r, code_arrayw_r;

  // sequencer
  btve_pkg::state_t state_r, state_nxt;
  btve_pkg::seg_t   seg_r, seg_nxt;
  btve_pkg::seg_t   first_seg, next_seg, sel_seg;

  // latched event word
  logic [1:0]  op_r;
  logic [15:0] id_r;
  logic [31:0] va_r, pa_r, size_r, hash_r, arg1_r, arg2_r;
  logic [63:0] cyc_r;
  logic [7:0]  ev_r;

  // record flags of the current event
  logic define_r, define_nxt;
  logic cycle_r, cycle_nxt;
  logic argw_r, argw_nxt;

  // trace state
  logic [63:0]      prev_cycle_r;
  logic [BKT_W-1:0] prev_bucket_r;
  logic [63:0]      delta_r;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  // bitmap and shared unit hookup
  logic              accept;
  logic              map_ready, map_rd_data, map_wr_en, tracked;
  logic [31:0]       in_id_ext, id_ext;
  logic              can_emit, emit;
  logic              bucket_diff;
  btve_pkg::vu_ctl_t  vu_ctl;
  btve_pkg::vu_stat_t vu_stat;
  logic [63:0]       ld_value;
  logic              ld_raw;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == btve_pkg::ST_IDLE) && map_ready;
  assign cfg_ready = 1'b1;

  assign in_id_ext = {16'd0, in_block_id};
  assign id_ext    = {16'd0, id_r};
  assign tracked   = id_ext < 32'(MAX_BLOCKS);
  assign map_wr_en = (state_r == btve_pkg::ST_LOOKUP) && (op_r == btve_pkg::OP_EXEC) && tracked;

  btve_seen_map #(
    .DEPTH (MAX_BLOCKS),
    .AW    (MAP_AW)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_id_ext[MAP_AW-1:0]),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (id_ext[MAP_AW-1:0]),
    .ready   (map_ready)
  );

  btve_varint_unit u_vu (
    .clk      (clk),
    .ctl      (vu_ctl),
    .ld_value (ld_value),
    .stat     (vu_stat)
  );

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_end_r    <= btve_pkg::RST_CODE_END;
      code_define_r <= btve_pkg::RST_CODE_DEFINE;
      code_cycle_r  <= btve_pkg::RST_CODE_CYCLE;
      code_arrayw_r <= btve_pkg::RST_CODE_ARRAYW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        btve_pkg::CFG_CODE_END:    code_end_r    <= cfg_wdata;
        btve_pkg::CFG_CODE_DEFINE: code_define_r <= cfg_wdata;
        btve_pkg::CFG_CODE_CYCLE:  code_cycle_r  <= cfg_wdata;
        btve_pkg::CFG_CODE_ARRAYW: code_arrayw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // latch the event word on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      id_r   <= in_block_id;
      va_r   <= in_virt_addr;
      pa_r   <= in_phys_addr;
      size_r <= in_block_bytes;
      hash_r <= in_block_hash;
      cyc_r  <= in_cycle_count;
      ev_r   <= in_event_code;
      arg1_r <= in_arg_first;
      arg2_r <= in_arg_second;
    end
  end

  // cycle bucket tracking and delta, settled in the lookup cycle
  assign bucket_diff = cyc_r[63:BUCKET_SHIFT] != prev_bucket_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cycle_r  <= '0;
      prev_bucket_r <= '0;
    end else if ((state_r == btve_pkg::ST_LOOKUP) && (op_r == btve_pkg::OP_EXEC)
                 && bucket_diff) begin
      prev_cycle_r  <= cyc_r;
      prev_bucket_r <= cyc_r[63:BUCKET_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == btve_pkg::ST_LOOKUP) begin
      delta_r <= (cyc_r >= prev_cycle_r) ? (cyc_r - prev_cycle_r) : '0;
    end
  end

  // record flags and first piece of the event
  always_comb begin
    define_nxt = define_r;
    cycle_nxt  = cycle_r;
    argw_nxt   = argw_r;
    first_seg  = btve_pkg::SEG_NONE;
    if (state_r == btve_pkg::ST_LOOKUP) begin
      define_nxt = !(tracked && map_rd_data);
      cycle_nxt  = bucket_diff;
      argw_nxt   = ev_r == code_arrayw_r;
    end
    unique case (op_r)
      btve_pkg::OP_EXEC: begin
        if (define_nxt) begin
          first_seg = btve_pkg::SEG_DEF_ZERO;
        end else if (cycle_nxt) begin
          first_seg = btve_pkg::SEG_CYC_ZERO;
        end else begin
          first_seg = btve_pkg::SEG_ID1;
        end
      end
      btve_pkg::OP_EVENT: first_seg = btve_pkg::SEG_EV_ZERO;
      btve_pkg::OP_END:   first_seg = btve_pkg::SEG_END_ZERO;
      default:            first_seg = btve_pkg::SEG_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    define_r <= define_nxt;
    cycle_r  <= cycle_nxt;
    argw_r   <= argw_nxt;
  end

  // piece that follows the current one
  always_comb begin
    case (seg_r)
      btve_pkg::SEG_DEF_ZERO:  next_seg = btve_pkg::SEG_DEF_CODE;
      btve_pkg::SEG_DEF_CODE:  next_seg = btve_pkg::SEG_DEF_ID;
      btve_pkg::SEG_DEF_ID:    next_seg = btve_pkg::SEG_DEF_VA;
      btve_pkg::SEG_DEF_VA:    next_seg = btve_pkg::SEG_DEF_PA;
      btve_pkg::SEG_DEF_PA:    next_seg = btve_pkg::SEG_DEF_SIZE;
      btve_pkg::SEG_DEF_SIZE:  next_seg = btve_pkg::SEG_DEF_HASH;
      btve_pkg::SEG_DEF_HASH:  next_seg = cycle_r ? btve_pkg::SEG_CYC_ZERO
                                                  : btve_pkg::SEG_ID1;
      btve_pkg::SEG_CYC_ZERO:  next_seg = btve_pkg::SEG_CYC_CODE;
      btve_pkg::SEG_CYC_CODE:  next_seg = btve_pkg::SEG_CYC_DELTA;
      btve_pkg::SEG_CYC_DELTA: next_seg = btve_pkg::SEG_ID1;
      btve_pkg::SEG_EV_ZERO:   next_seg = btve_pkg::SEG_EV_CODE;
      btve_pkg::SEG_EV_CODE:   next_seg = argw_r ? btve_pkg::SEG_ARG1 : btve_pkg::SEG_NONE;
      btve_pkg::SEG_ARG1:      next_seg = btve_pkg::SEG_ARG2;
      btve_pkg::SEG_END_ZERO:  next_seg = btve_pkg::SEG_END_CODE;
      default:                 next_seg = btve_pkg::SEG_NONE;
    endcase
  end

  // value to load into the shift unit
  assign sel_seg = (state_r == btve_pkg::ST_LOOKUP) ? first_seg : next_seg;

  always_comb begin
    ld_value = '0;
    ld_raw   = 1'b0;
    case (sel_seg)
      btve_pkg::SEG_DEF_CODE:  begin ld_value = {56'd0, code_define_r}; ld_raw = 1'b1; end
      btve_pkg::SEG_CYC_CODE:  begin ld_value = {56'd0, code_cycle_r};  ld_raw = 1'b1; end
      btve_pkg::SEG_EV_CODE:   begin ld_value = {56'd0, ev_r};          ld_raw = 1'b1; end
      btve_pkg::SEG_END_CODE:  begin ld_value = {56'd0, code_end_r};    ld_raw = 1'b1; end
      btve_pkg::SEG_DEF_ID:    ld_value = {48'd0, id_r};
      btve_pkg::SEG_DEF_VA:    ld_value = {32'd0, va_r};
      btve_pkg::SEG_DEF_PA:    ld_value = {32'd0, pa_r};
      btve_pkg::SEG_DEF_SIZE:  ld_value = {32'd0, size_r};
      btve_pkg::SEG_DEF_HASH:  ld_value = {32'd0, hash_r};
      btve_pkg::SEG_CYC_DELTA: ld_value = delta_r;
      btve_pkg::SEG_ID1:       ld_value = {47'd0, {1'b0, id_r} + 17'd1};
      btve_pkg::SEG_ARG1:      ld_value = {32'd0, arg1_r};
      btve_pkg::SEG_ARG2:      ld_value = {32'd0, arg2_r};
      default:                 ld_value = '0;
    endcase
  end

  // sequencer: lookup, then one byte a cycle while the output can take it
  assign can_emit = !out_valid_r || out_ready;
  assign emit     = (state_r == btve_pkg::ST_EMIT) && can_emit;

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    vu_ctl.load   = 1'b0;
    vu_ctl.step   = 1'b0;
    vu_ctl.raw    = ld_raw;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      btve_pkg::ST_IDLE: begin
        if (accept && (in_op != btve_pkg::OP_NONE)) begin
          state_nxt = btve_pkg::ST_LOOKUP;
        end
      end
      btve_pkg::ST_LOOKUP: begin
        vu_ctl.load = 1'b1;
        seg_nxt     = first_seg;
        state_nxt   = btve_pkg::ST_EMIT;
      end
      btve_pkg::ST_EMIT: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          if (vu_stat.more) begin
            vu_ctl.step = 1'b1;
          end else if (next_seg != btve_pkg::SEG_NONE) begin
            vu_ctl.load = 1'b1;
            seg_nxt     = next_seg;
          end else begin
            state_nxt = btve_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = btve_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btve_pkg::ST_IDLE;
      seg_r       <= btve_pkg::SEG_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= vu_stat.data;
      out_last_r <= !vu_stat.more && (next_seg == btve_pkg::SEG_NONE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ===== sv/btve_checker.sv =====
// Port-level checks of the varint trace encoder, bound to the top level.
module btve_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  // a real event keeps the block busy in the following cycle
  a_busy_after_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != btve_pkg::OP_NONE) |=> !in_ready)
    else $error("input taken again straight after an event");

  // an unused op code leaves the block ready
  a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == btve_pkg::OP_NONE) |=> in_ready)
    else $error("unused op code stalled the input");

  // reset empties the output and starts the bitmap sweep
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("output or input ready after reset");

endmodule

bind block_trace_varint_encoder_core btve_checker u_btve_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench of the varint trace encoder core.
`timescale 1ns / 100ps

module testbench;

  localparam int BLOCK_LIMIT  = 65536;
  localparam int BUCKET_BITS  = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  // watchdog limit, with room for the bitmap sweep of all BLOCK_LIMIT entries
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  // register indexes with no register behind them
  localparam logic [7:0] CFG_BEYOND_FIRST = 8'd4;
  localparam logic [7:0] CFG_BEYOND_TOP   = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] block_id;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [31:0] block_bytes;
    logic [31:0] block_hash;
    logic [63:0] cycle_count;
    logic [7:0]  event_code;
    logic [31:0] arg_first;
    logic [31:0] arg_second;
  } trace_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [15:0] in_block_id;
  logic [31:0] in_virt_addr;
  logic [31:0] in_phys_addr;
  logic [31:0] in_block_bytes;
  logic [31:0] in_block_hash;
  logic [63:0] in_cycle_count;
  logic [7:0]  in_event_code;
  logic [31:0] in_arg_first;
  logic [31:0] in_arg_second;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  // mirror of the header codes
  logic [7:0] code_end_r = btve_pkg::RST_CODE_END;
  logic [7:0] code_def_r = btve_pkg::RST_CODE_DEFINE;
  logic [7:0] code_cyc_r = btve_pkg::RST_CODE_CYCLE;
  logic [7:0] code_aw_r  = btve_pkg::RST_CODE_ARRAYW;

  // mirror of the encoder state
  bit          seen_blk [0:BLOCK_LIMIT-1];
  logic [63:0] last_cycle  = '0;
  logic [63:0] last_bucket = '0;

  // bytes of the word being encoded, then the stream still owed by the block
  logic [7:0] enc_buf[$];
  logic [7:0] byte_q[$];
  bit         last_q[$];

  logic [63:0] cycle_now = '0;
  bit          steady    = 1'b0;
  int          hold_req  = 0;
  int          hold_ack  = 0;
  int          hold_left = 0;
  int          failures  = 0;

  block_trace_varint_encoder_core #(
    .MAX_BLOCKS(BLOCK_LIMIT),
    .BUCKET_SHIFT(BUCKET_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_block_id(in_block_id),
    .in_virt_addr(in_virt_addr),
    .in_phys_addr(in_phys_addr),
    .in_block_bytes(in_block_bytes),
    .in_block_hash(in_block_hash),
    .in_cycle_count(in_cycle_count),
    .in_event_code(in_event_code),
    .in_arg_first(in_arg_first),
    .in_arg_second(in_arg_second),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // LEB128: seven bits a byte, low group first, bit 7 marks more to come
  function automatic void put_varint(input logic [63:0] v);
    while (v >= 64'h80) begin
      enc_buf.push_back({1'b1, v[6:0]});
      v = v >> 7;
    end
    enc_buf.push_back(v[7:0]);
  endfunction

  // work out the byte stream of one accepted word and queue it
  function automatic void encode_word(input trace_word_t w);
    logic [63:0] bucket;
    bit          known;
    enc_buf.delete();
    case (w.op)
      btve_pkg::OP_EXEC: begin
        bucket = w.cycle_count >> BUCKET_BITS;
        known  = 1'b0;
        if (w.block_id < BLOCK_LIMIT) begin
          known = seen_blk[w.block_id];
          seen_blk[w.block_id] = 1'b1;
        end
        if (!known) begin
          enc_buf.push_back(8'h00);
          enc_buf.push_back(code_def_r);
          put_varint({48'd0, w.block_id});
          put_varint({32'd0, w.virt_addr});
          put_varint({32'd0, w.phys_addr});
          put_varint({32'd0, w.block_bytes});
          put_varint({32'd0, w.block_hash});
        end
        if (bucket != last_bucket) begin
          last_bucket = bucket;
          enc_buf.push_back(8'h00);
          enc_buf.push_back(code_cyc_r);
          // a count that ran backwards gives a zero delta
          put_varint(w.cycle_count >= last_cycle ? w.cycle_count - last_cycle : 64'd0);
          last_cycle = w.cycle_count;
        end
        put_varint({48'd0, w.block_id} + 64'd1);
      end
      btve_pkg::OP_EVENT: begin
        enc_buf.push_back(8'h00);
        enc_buf.push_back(w.event_code);
        if (w.event_code == code_aw_r) begin
          put_varint({32'd0, w.arg_first});
          put_varint({32'd0, w.arg_second});
        end
      end
      btve_pkg::OP_END: begin
        enc_buf.push_back(8'h00);
        enc_buf.push_back(code_end_r);
      end
      default: ;
    endcase
    for (int i = 0; i < enc_buf.size(); i++) begin
      byte_q.push_back(enc_buf[i]);
      last_q.push_back(i == enc_buf.size() - 1);
    end
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 14);
  endfunction

  // all fields random, op included
  function automatic trace_word_t noise_word();
    trace_word_t w;
    w.op          = 2'($urandom);
    w.block_id    = 16'($urandom);
    w.virt_addr   = $urandom;
    w.phys_addr   = $urandom;
    w.block_bytes = $urandom;
    w.block_hash  = $urandom;
    w.cycle_count = {$urandom, $urandom};
    w.event_code  = 8'($urandom);
    w.arg_first   = $urandom;
    w.arg_second  = $urandom;
    return w;
  endfunction

  // plausible trace: mostly executes from a small id pool with a rising count
  function automatic trace_word_t traffic_word();
    trace_word_t w;
    int          pick;
    w    = noise_word();
    pick = $urandom_range(99);
    if (pick < 68) begin
      w.op = btve_pkg::OP_EXEC;
      if ($urandom_range(19) == 0) w.block_id = 16'($urandom);
      else w.block_id = 16'($urandom_range(47));
      case ($urandom_range(19))
        0: cycle_now = {$urandom, $urandom};
        1: cycle_now = cycle_now - 64'($urandom_range(100000));
        default: cycle_now = cycle_now + 64'($urandom_range(20000));
      endcase
      w.cycle_count = cycle_now;
    end else if (pick < 88) begin
      w.op = btve_pkg::OP_EVENT;
      if ($urandom_range(1) == 1) w.event_code = code_aw_r;
    end else if (pick < 94) begin
      w.op = btve_pkg::OP_END;
    end else begin
      w.op = btve_pkg::OP_NONE;
    end
    return w;
  endfunction

  // offer one word, hold it until taken, then predict its bytes
  task automatic send_word(input trace_word_t w);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= w.op;
    in_block_id    <= w.block_id;
    in_virt_addr   <= w.virt_addr;
    in_phys_addr   <= w.phys_addr;
    in_block_bytes <= w.block_bytes;
    in_block_hash  <= w.block_hash;
    in_cycle_count <= w.cycle_count;
    in_event_code  <= w.event_code;
    in_arg_first   <= w.arg_first;
    in_arg_second  <= w.arg_second;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_word(w);
  endtask

  // stop sending and let every owed byte come out, plus the tail of a dropped word
  task automatic settle();
    in_valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_code(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      btve_pkg::CFG_CODE_END:    code_end_r = val;
      btve_pkg::CFG_CODE_DEFINE: code_def_r = val;
      btve_pkg::CFG_CODE_CYCLE:  code_cyc_r = val;
      btve_pkg::CFG_CODE_ARRAYW: code_aw_r  = val;
      default: ;
    endcase
  endtask

  task automatic program_codes(input logic [7:0] c_end, input logic [7:0] c_def,
                               input logic [7:0] c_cyc, input logic [7:0] c_aw);
    settle();
    write_code(btve_pkg::CFG_CODE_END, c_end);
    write_code(btve_pkg::CFG_CODE_DEFINE, c_def);
    write_code(btve_pkg::CFG_CODE_CYCLE, c_cyc);
    write_code(btve_pkg::CFG_CODE_ARRAYW, c_aw);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // directed words under the reset codes: extremes, clamping, every op
  task automatic test_reset_codes();
    trace_word_t w;
    // first sight of block 0, count still in bucket zero
    w = noise_word(); w.op = btve_pkg::OP_EXEC; w.block_id = 16'd0;
    w.cycle_count = 64'd0;
    send_word(w);
    // same block, same bucket: id byte only
    w = noise_word(); w.op = btve_pkg::OP_EXEC; w.block_id = 16'd0;
    w.cycle_count = 64'h0000_FFFF;
    send_word(w);
    // longest word: top id, all-ones fields and count
    w = noise_word(); w.op = btve_pkg::OP_EXEC; w.block_id = 16'hFFFF;
    w.virt_addr = '1; w.phys_addr = '1; w.block_bytes = '1; w.block_hash = '1;
    w.cycle_count = '1;
    send_word(w);
    // count goes backwards: delta clamped to zero
    w = noise_word(); w.op = btve_pkg::OP_EXEC; w.block_id = 16'hFFFF;
    w.cycle_count = 64'd0;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_EXEC; w.block_id = 16'h007F;
    w.cycle_count = 64'h1_0000;
    w.virt_addr = '0; w.phys_addr = '0; w.block_bytes = '0; w.block_hash = '0;
    send_word(w);
    // array write with both argument extremes
    w = noise_word(); w.op = btve_pkg::OP_EVENT; w.event_code = btve_pkg::RST_CODE_ARRAYW;
    w.arg_first = '0; w.arg_second = '1;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_EVENT; w.event_code = 8'hFF;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_EVENT; w.event_code = 8'h00;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_END;
    send_word(w);
    // unused op: dropped silently
    w = noise_word(); w.op = btve_pkg::OP_NONE;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_EXEC; w.block_id = 16'h007F;
    w.cycle_count = 64'h1_8000;
    send_word(w);
  endtask

  // header codes at both extremes, and writes to indexes with no register
  task automatic test_code_registers();
    trace_word_t w;
    program_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    w = noise_word(); w.op = btve_pkg::OP_EVENT; w.event_code = 8'hFF;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_EXEC; w.block_id = 16'd200;
    w.cycle_count = 64'h0123_4567_89AB;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_END;
    send_word(w);
    settle();
    write_code(CFG_BEYOND_FIRST, 8'h00);
    write_code(CFG_BEYOND_TOP, 8'h00);
    cfg_valid <= 1'b0;
    // codes must be untouched
    w = noise_word(); w.op = btve_pkg::OP_EVENT; w.event_code = 8'hFF;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_END;
    send_word(w);
    program_codes(8'h00, 8'h00, 8'h00, 8'h00);
    w = noise_word(); w.op = btve_pkg::OP_EVENT; w.event_code = 8'h00;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_EXEC; w.block_id = 16'd300;
    w.cycle_count = 64'h0123_4568_0000;
    send_word(w);
    w = noise_word(); w.op = btve_pkg::OP_END;
    send_word(w);
    cycle_now = 64'h0123_4568_0000;
  endtask

  task automatic test_random_mix(input int count);
    trace_word_t w;
    int          sent;
    program_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    sent = 0;
    while (sent < count) begin
      w = traffic_word();
      send_word(w);
      if (w.op != btve_pkg::OP_NONE) sent++;
    end
  endtask

  // no idling on either side
  task automatic test_steady_stream(input int count);
    trace_word_t w;
    int          sent;
    steady = 1'b1;
    sent   = 0;
    while (sent < count) begin
      w = traffic_word();
      send_word(w);
      if (w.op != btve_pkg::OP_NONE) sent++;
    end
    steady = 1'b0;
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_output_stall(input int count);
    trace_word_t w;
    int          sent;
    hold_req = hold_req + 1;
    sent     = 0;
    while (sent < count) begin
      w = traffic_word();
      send_word(w);
      if (w.op != btve_pkg::OP_NONE) sent++;
    end
  endtask

  // byte receiver: checks each word taken and decides out_ready for the next edge
  always @(posedge clk) begin : byte_sink
    logic [7:0] want_byte;
    bit         want_last;
    if (rst_n && out_valid && out_ready) begin
      if (byte_q.size() == 0) begin
        $error("unexpected word: out_byte %02h out_last %0b", out_byte, out_last);
        failures++;
      end else begin
        want_byte = byte_q.pop_front();
        want_last = last_q.pop_front();
        if (out_byte !== want_byte) begin
          $error("out_byte mismatch: expected %02h, got %02h", want_byte, out_byte);
          failures++;
        end
        if (out_last !== want_last) begin
          $error("out_last mismatch: expected %0b, got %0b", want_last, out_last);
          failures++;
        end
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
    end
  end

  initial begin : run
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_op          <= btve_pkg::OP_NONE;
    in_block_id    <= '0;
    in_virt_addr   <= '0;
    in_phys_addr   <= '0;
    in_block_bytes <= '0;
    in_block_hash  <= '0;
    in_cycle_count <= '0;
    in_event_code  <= '0;
    in_arg_first   <= '0;
    in_arg_second  <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_codes();
    test_code_registers();
    test_random_mix(85);
    test_steady_stream(60);
    test_output_stall(30);
    test_random_mix(75);
    settle();

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
